// File: hw/rtl/pls_pkg.sv
// ============================================================================
// pls_pkg
// Shared types and sizes for the positional list store.
// ============================================================================
package pls_pkg;

    localparam int DEPTH   = 32;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 6;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W + 1 : POS_W + 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } pls_cmd_t;

    typedef struct packed {
        logic               ins;
        logic               del;
        logic [IDX_W-1:0]   idx;
        logic [WORD_W-1:0]  value;
    } pls_shift_t;

endpackage

// File: hw/rtl/positional_list_store_top.sv
// ============================================================================
// positional_list_store_top
// Ordered list of signed words with insert, delete, read and clear by position.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after the input beat is taken.
// Throughput: one command per cycle while the result is drained; every cell of the row shifts at once.
// A new beat is taken while the result register is empty or being drained.
// Reset: synchronous, active low; clears the length and the result valid.
// Stored words are not cleared.
// ============================================================================
module positional_list_store_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data_out[31:0], count[37:32], is_empty[38], pad
    output logic        m_tuser    // status[0]
);
    import pls_pkg::*;

    pls_cmd_t            cmd;
    logic [POS_W-1:0]    pos;
    logic [WORD_W-1:0]   value;
    logic                accept;

    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic                status_reg;
    logic                status_next;
    logic [WORD_W-1:0]   data_reg;
    logic [WORD_W-1:0]   data_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                empty_reg;
    logic                empty_next;

    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    len_ext;
    logic                ins_ok;
    logic                acc_ok;
    logic [IDX_W-1:0]    idx;
    logic [WORD_W-1:0]   rd_data;
    pls_shift_t          ctl;

    assign cmd    = pls_cmd_t'(s_tuser);
    assign pos    = s_tdata[POS_W-1:0];
    assign value  = s_tdata[POS_W+WORD_W-1:POS_W];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    assign pos_ext = CMP_W'(pos);
    assign len_ext = CMP_W'(len_reg);
    assign ins_ok  = (pos != '0) && (pos_ext <= len_ext + CMP_W'(1))
                     && (len_ext != CMP_W'(DEPTH));
    assign acc_ok  = (pos != '0) && (pos_ext <= len_ext);
    assign idx     = IDX_W'(pos - POS_W'(1));

    always_comb begin
        ctl.ins   = accept && (cmd == CMD_INSERT) && ins_ok;
        ctl.del   = accept && (cmd == CMD_DELETE) && acc_ok;
        ctl.idx   = idx;
        ctl.value = value;
    end

    pls_chain u_chain (
        .aclk    (aclk),
        .ctl     (ctl),
        .rd_idx  (idx),
        .rd_data (rd_data)
    );

    always_comb begin
        len_next     = len_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        data_next    = data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = 1'b0;
            data_next    = '0;
            case (cmd)
                CMD_INSERT: begin
                    if (ins_ok) begin
                        len_next = len_reg + LEN_W'(1);
                    end else begin
                        status_next = 1'b1;
                    end
                end
                CMD_DELETE: begin
                    if (acc_ok) begin
                        len_next  = len_reg - LEN_W'(1);
                        data_next = rd_data;
                    end else begin
                        status_next = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (acc_ok) begin
                        data_next = rd_data;
                    end else begin
                        status_next = 1'b1;
                    end
                end
                default: begin
                    len_next = '0;
                end
            endcase
        end
        count_next = accept ? COUNT_W'(len_next) : count_reg;
        empty_next = accept ? (len_next == '0) : empty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        data_reg   <= data_next;
        count_reg  <= count_next;
        empty_reg  <= empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, empty_reg, count_reg, data_reg};

endmodule

// File: hw/rtl/pls_cell.sv
// ============================================================================
// pls_cell
// One list entry: hold, take the left word, take the right word or load.
// ============================================================================
module pls_cell (
    input  logic                        aclk,
    input  pls_pkg::pls_shift_t         ctl,
    input  logic [pls_pkg::IDX_W-1:0]   cell_idx,
    input  logic [pls_pkg::WORD_W-1:0]  left_data,
    input  logic [pls_pkg::WORD_W-1:0]  right_data,
    output logic [pls_pkg::WORD_W-1:0]  data
);
    import pls_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.ins && (cell_idx > ctl.idx)) begin
            data_next = left_data;
        end else if (ctl.ins && (cell_idx == ctl.idx)) begin
            data_next = ctl.value;
        end else if (ctl.del && (cell_idx >= ctl.idx)) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: hw/rtl/pls_chain.sv
// ============================================================================
// pls_chain
// Row of list cells with neighbor links and a read select by position.
// ============================================================================
module pls_chain (
    input  logic                        aclk,
    input  pls_pkg::pls_shift_t         ctl,
    input  logic [pls_pkg::IDX_W-1:0]   rd_idx,
    output logic [pls_pkg::WORD_W-1:0]  rd_data
);
    import pls_pkg::*;

    logic [WORD_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = ctl.value;
        end else begin : g_left
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_data[i+1];
        end

        pls_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .cell_idx   (IDX_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (rd_idx == IDX_W'(i)) begin
                rd_data = rd_data | cell_data[i];
            end
        end
    end

endmodule
